// ===== hw/rtl/isf_pkg.sv =====
// shared constants and types for the instance filter and sort unit
package isf_pkg;

  // default number of entity slots per frame
  localparam int unsigned IsfCapacity = 64;

  // fixed field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned FlagW  = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned SortW  = 2 * KeyW + IdxW;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 104;

  // one stored entry
  typedef struct packed {
    logic [KeyW-1:0]  material;
    logic [KeyW-1:0]  mesh;
    logic [IdxW-1:0]  index;
    logic [FlagW-1:0] flags;
  } entry_t;

endpackage

// ===== hw/rtl/instance_filter_sort_unit.sv =====
// instance filter and sort unit: filters entity records, emits survivors in key order
// an input transaction is taken each cycle while a frame is collected
// after the last entity, each result takes one memory scan over the n kept entries
// through the single registered read port; the input is held off meanwhile
// reset (rst_ni low, asynchronous) clears the arrival and kept counters, valid and
// overflow flags and the state, and sets active_mask to 1; payload registers and the
// entry memory are not cleared, only entries written in the current frame are read
module instance_filter_sort_unit #(
  parameter int unsigned CAPACITY = isf_pkg::IsfCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [31:0]                  cfg_wdata_i,      // active_mask
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entity_flags [31:0], material_id [63:32], mesh_id [95:64]
  input  logic [isf_pkg::InDataW-1:0]  s_axis_tdata,
  // visible [0], has_flags [1]
  input  logic [1:0]                   s_axis_tuser,
  input  logic                         s_axis_tlast,     // last_entity
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_material [31:0], out_mesh [63:32], out_entity_index [69:64],
  // out_flags [101:70], zero [103:102]
  output logic [isf_pkg::OutDataW-1:0] m_axis_tdata,
  // empty_frame [0], truncated [1]
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast      // last_result
);
  import isf_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] StIn   = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [31:0]   active_mask_q;
  logic [CW-1:0] arrival_q, arrival_d;
  logic [CW-1:0] kept_q, kept_d;
  logic          overflow_q, overflow_d;
  logic          trunc_q, trunc_d;
  logic [CW-1:0] emitted_q, emitted_d;
  logic [CW-1:0] rd_addr_q, rd_addr_d;
  logic          rv_q, rl_q;
  logic          prev_v_q, prev_v_d;
  logic [SortW-1:0] prev_q, prev_d;
  logic          best_v_q, best_v_d;
  entry_t        best_q, best_d;
  entry_t        out_q, out_d;
  logic          out_last_q, out_last_d, out_empty_q, out_empty_d;

  entry_t        mem [CAPACITY];
  entry_t        rdata_q;
  entry_t        wdata;
  logic          mem_we;
  logic          issue;

  logic          in_acc, out_acc, keep;
  logic          has_room;
  logic [31:0]   in_flags;
  logic [SortW-1:0] rkey, bkey;
  logic          cand, better;
  entry_t        best_now;
  logic          best_now_v;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == StIn);
  assign m_axis_tvalid = (state_q == StOut);

  // filter decision
  assign has_room = (arrival_q < CW'(CAPACITY));
  assign keep     = s_axis_tuser[0] &&
                    !(s_axis_tuser[1] && ((s_axis_tdata[31:0] & active_mask_q) == '0));
  assign in_flags = s_axis_tuser[1] ? s_axis_tdata[31:0] : '0;
  assign mem_we   = in_acc && has_room && keep;
  assign wdata    = '{material: s_axis_tdata[63:32], mesh: s_axis_tdata[95:64],
                      index: IdxW'(arrival_q), flags: in_flags};

  // scan compare: smallest key above the one emitted last
  assign issue  = (state_q == StScan) && (rd_addr_q < kept_q);
  assign rkey   = {rdata_q.material, rdata_q.mesh, rdata_q.index};
  assign bkey   = {best_q.material, best_q.mesh, best_q.index};
  assign cand   = !prev_v_q || (rkey > prev_q);
  assign better = rv_q && cand && (!best_v_q || (rkey < bkey));
  assign best_now   = better ? rdata_q : best_q;
  assign best_now_v = better || best_v_q;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[kept_q[AW-1:0]] <= wdata;
    end
    rdata_q <= mem[rd_addr_q[AW-1:0]];
  end

  // control next state
  always_comb begin
    state_d    = state_q;
    arrival_d  = arrival_q;
    kept_d     = kept_q;
    overflow_d = overflow_q;
    trunc_d    = trunc_q;
    emitted_d  = emitted_q;
    rd_addr_d  = rd_addr_q;
    prev_v_d   = prev_v_q;
    prev_d     = prev_q;
    best_v_d   = best_v_q;
    best_d     = best_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_empty_d = out_empty_q;
    case (state_q)
      StIn: begin
        if (in_acc) begin
          if (has_room) begin
            arrival_d = arrival_q + CW'(1);
            if (keep) begin
              kept_d = kept_q + CW'(1);
            end
          end else begin
            overflow_d = 1'b1;
          end
          if (s_axis_tlast) begin
            trunc_d   = overflow_q || !has_room;
            emitted_d = '0;
            prev_v_d  = 1'b0;
            rd_addr_d = '0;
            best_v_d  = 1'b0;
            if (kept_d == '0) begin
              out_d       = '0;
              out_last_d  = 1'b1;
              out_empty_d = 1'b1;
              state_d     = StOut;
            end else begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        if (issue) begin
          rd_addr_d = rd_addr_q + CW'(1);
        end
        best_d   = best_now;
        best_v_d = best_now_v;
        if (rv_q && rl_q) begin
          out_d       = best_now;
          out_last_d  = (emitted_q + CW'(1) == kept_q);
          out_empty_d = 1'b0;
          prev_d      = {best_now.material, best_now.mesh, best_now.index};
          prev_v_d    = 1'b1;
          state_d     = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (out_last_q) begin
            arrival_d  = '0;
            kept_d     = '0;
            overflow_d = 1'b0;
            state_d    = StIn;
          end else begin
            emitted_d = emitted_q + CW'(1);
            rd_addr_d = '0;
            best_v_d  = 1'b0;
            state_d   = StScan;
          end
        end
      end
      default: state_d = StIn;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIn;
      active_mask_q <= 32'd1;
      arrival_q     <= '0;
      kept_q        <= '0;
      overflow_q    <= 1'b0;
      rv_q          <= 1'b0;
      rl_q          <= 1'b0;
      prev_v_q      <= 1'b0;
      best_v_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        active_mask_q <= cfg_wdata_i;
      end
      arrival_q  <= arrival_d;
      kept_q     <= kept_d;
      overflow_q <= overflow_d;
      rv_q       <= issue;
      rl_q       <= issue && (rd_addr_q + CW'(1) == kept_q);
      prev_v_q   <= prev_v_d;
      best_v_q   <= best_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    trunc_q     <= trunc_d;
    emitted_q   <= emitted_d;
    rd_addr_q   <= rd_addr_d;
    prev_q      <= prev_d;
    best_q      <= best_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign m_axis_tdata = {2'b00, out_q.flags, out_q.index, out_q.mesh, out_q.material};
  assign m_axis_tuser = {trunc_q, out_empty_q};
  assign m_axis_tlast = out_last_q;

endmodule

// ===== hw/rtl/isf_checker.sv =====
// port checker for the instance filter and sort unit, with its bind
module isf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [isf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser,
  input logic                         m_axis_tlast
);
  import isf_pkg::*;

  // input is held off while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // empty frame result is the last one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty result without last");

  // empty frame result carries zero data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty result with data");

endmodule

bind instance_filter_sort_unit isf_checker u_isf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
